// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file (rosd_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/rosd_pkg.sv =====
package rosd_pkg;

	localparam int OFFSET_BITS_DEF = 64;

	// opcodes (high nibble of an opcode byte)
	localparam logic [3:0] OP_DONE       = 4'h0;
	localparam logic [3:0] OP_SET_KIND   = 4'h1;
	localparam logic [3:0] OP_SET_SEG    = 4'h2;
	localparam logic [3:0] OP_ADD_ULEB   = 4'h3;
	localparam logic [3:0] OP_ADD_IMM    = 4'h4;
	localparam logic [3:0] OP_RUN_IMM    = 4'h5;
	localparam logic [3:0] OP_RUN_ULEB   = 4'h6;
	localparam logic [3:0] OP_RUN_SKIP   = 4'h7;
	localparam logic [3:0] OP_RUN_STRIDE = 4'h8;
	localparam logic [3:0] OP_NONE       = 4'h0;

	// operand phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FIRST  = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;

	// result status codes
	localparam logic [1:0] ST_RUN     = 2'd0;
	localparam logic [1:0] ST_FINISH  = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_TRUNC   = 2'd3;

	// configuration registers
	localparam logic       REG_POINTER_BYTES = 1'b0;
	localparam logic [3:0] PTR_BYTES_RST     = 4'd8;
	localparam logic [3:0] PTR_BYTES_SMALL   = 4'd4;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  segment;
		logic [63:0] offset;
		logic [63:0] count;
		logic [63:0] stride;
		logic [3:0]  kind;
		logic        stream_end;
	} rosd_res_t;

endpackage

// ===== rtl/rosd_regs.sv =====
module rosd_regs import rosd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [3:0]  ptr_bytes
);

	logic [3:0] ptr_bytes_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_POINTER_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_bytes_q <= PTR_BYTES_RST;
		end else if (wr_en) begin
			ptr_bytes_q <= pwdata[3:0];
		end
	end

	assign prdata    = (paddr[2] == REG_POINTER_BYTES) ? {28'd0, ptr_bytes_q} : 32'd0;
	assign ptr_bytes = ptr_bytes_q;

endmodule

// ===== rtl/rosd_core.sv =====
module rosd_core import rosd_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] in_byte,
	input  logic       in_final,
	input  logic [3:0] ptr_bytes,
	output logic       res_valid,
	output rosd_res_t  res
);

	logic [3:0]             pend_q, pend_n;
	logic [1:0]             phase_q, phase_n;
	logic [63:0]            acc_q, acc_n;
	logic [6:0]             shift_q, shift_n;
	logic [63:0]            first_q, first_n;
	logic [3:0]             seg_q, seg_n;
	logic [OFFSET_BITS-1:0] off_q, off_n;
	logic [3:0]             kind_q, kind_n;
	logic                   done_q, done_n;
	// offset + partial products of count times the second operand so far;
	// count * slot is added at the last digit, with the slot size then in force
	logic [OFFSET_BITS-1:0] prod_q, prod_n;

	logic [3:0]  op;
	logic [3:0]  imm;
	logic [6:0]  b7;
	logic        cont;
	logic [63:0] slot;
	logic [1:0]  slot_sh;
	logic        sh_ok;
	logic [63:0] acc_new;
	logic [6:0]  shift_cont;
	logic [63:0] part_mul;
	logic [63:0] partial;
	logic [OFFSET_BITS-1:0] prod_sum;
	logic [63:0] stride_skip;

	assign op      = in_byte[7:4];
	assign imm     = in_byte[3:0];
	assign b7      = in_byte[6:0];
	assign cont    = in_byte[7];
	assign slot    = (ptr_bytes == PTR_BYTES_SMALL) ? 64'd4 : 64'd8;
	assign slot_sh = (ptr_bytes == PTR_BYTES_SMALL) ? 2'd2 : 2'd3;

	// ULEB digit merge; digits at weight 2^64 and above drop out
	assign sh_ok      = !shift_q[6];
	assign acc_new    = sh_ok ? (acc_q | (64'(b7) << shift_q[5:0])) : acc_q;
	assign shift_cont = (shift_q < 7'd70) ? shift_q + 7'd7 : shift_q;

	// count * (slot + v) for the stride opcode, one 64x7 partial per digit
	assign part_mul    = first_q * 64'(b7);
	assign partial     = sh_ok ? (part_mul << shift_q[5:0]) : 64'd0;
	assign prod_sum    = prod_q + OFFSET_BITS'(partial);
	assign stride_skip = slot + acc_new;

	always_comb begin
		pend_n    = pend_q;
		phase_n   = phase_q;
		acc_n     = acc_q;
		shift_n   = shift_q;
		first_n   = first_q;
		seg_n     = seg_q;
		off_n     = off_q;
		kind_n    = kind_q;
		done_n    = done_q;
		prod_n    = prod_q;
		res_valid = 1'b0;
		res       = '0;

		if (done_q) begin
			if (in_final) begin
				pend_n  = OP_NONE;
				phase_n = PH_IDLE;
				acc_n   = '0;
				shift_n = '0;
				first_n = '0;
				seg_n   = '0;
				off_n   = '0;
				kind_n  = '0;
				done_n  = 1'b0;
			end
		end else begin
			if (phase_q == PH_IDLE) begin
				acc_n   = '0;
				shift_n = '0;
				unique case (op)
					OP_DONE: begin
						res_valid  = 1'b1;
						res.status = ST_FINISH;
						done_n     = 1'b1;
					end
					OP_SET_KIND: begin
						kind_n = imm;
					end
					OP_SET_SEG: begin
						seg_n   = imm;
						pend_n  = op;
						phase_n = PH_FIRST;
					end
					OP_ADD_ULEB, OP_RUN_ULEB, OP_RUN_SKIP, OP_RUN_STRIDE: begin
						pend_n  = op;
						phase_n = PH_FIRST;
					end
					OP_ADD_IMM: begin
						off_n = off_q + OFFSET_BITS'(64'(imm) << slot_sh);
					end
					OP_RUN_IMM: begin
						res_valid   = 1'b1;
						res.status  = ST_RUN;
						res.segment = seg_q;
						res.offset  = 64'(off_q);
						res.count   = 64'(imm);
						res.stride  = slot;
						res.kind    = kind_q;
						off_n       = off_q + OFFSET_BITS'(64'(imm) << slot_sh);
					end
					default: begin
						res_valid  = 1'b1;
						res.status = ST_UNKNOWN;
						done_n     = 1'b1;
					end
				endcase
				if (in_final && phase_n != PH_IDLE) begin
					res_valid = 1'b1;
					res       = '0;
					res.status = ST_TRUNC;
				end
			end else begin
				acc_n   = acc_new;
				shift_n = shift_cont;
				if (phase_q == PH_SECOND) begin
					prod_n = prod_sum;
				end
				if (cont) begin
					if (in_final) begin
						res_valid  = 1'b1;
						res.status = ST_TRUNC;
					end
				end else begin
					acc_n   = '0;
					shift_n = '0;
					if (pend_q == OP_RUN_STRIDE && phase_q == PH_FIRST) begin
						first_n = acc_new;
						phase_n = PH_SECOND;
						prod_n  = off_q;
						if (in_final) begin
							res_valid  = 1'b1;
							res.status = ST_TRUNC;
						end
					end else begin
						unique case (pend_q)
							OP_SET_SEG: begin
								off_n = OFFSET_BITS'(acc_new);
							end
							OP_ADD_ULEB: begin
								off_n = off_q + OFFSET_BITS'(acc_new);
							end
							OP_RUN_ULEB: begin
								res_valid   = 1'b1;
								res.status  = ST_RUN;
								res.segment = seg_q;
								res.offset  = 64'(off_q);
								res.count   = acc_new;
								res.stride  = slot;
								res.kind    = kind_q;
								off_n       = off_q + OFFSET_BITS'(acc_new << slot_sh);
							end
							OP_RUN_SKIP: begin
								res_valid   = 1'b1;
								res.status  = ST_RUN;
								res.segment = seg_q;
								res.offset  = 64'(off_q);
								res.count   = 64'd1;
								res.stride  = stride_skip;
								res.kind    = kind_q;
								off_n       = off_q + OFFSET_BITS'(stride_skip);
							end
							OP_RUN_STRIDE: begin
								res_valid   = 1'b1;
								res.status  = ST_RUN;
								res.segment = seg_q;
								res.offset  = 64'(off_q);
								res.count   = first_q;
								res.stride  = stride_skip;
								res.kind    = kind_q;
								off_n       = prod_sum + OFFSET_BITS'(first_q << slot_sh);
							end
							default: begin
							end
						endcase
						pend_n  = OP_NONE;
						phase_n = PH_IDLE;
					end
				end
			end

			if (in_final) begin
				if (!res_valid) begin
					res_valid  = 1'b1;
					res.status = ST_FINISH;
				end
				res.stream_end = 1'b1;
				pend_n  = OP_NONE;
				phase_n = PH_IDLE;
				acc_n   = '0;
				shift_n = '0;
				first_n = '0;
				seg_n   = '0;
				off_n   = '0;
				kind_n  = '0;
				done_n  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= OP_NONE;
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			shift_q <= '0;
			first_q <= '0;
			seg_q   <= '0;
			off_q   <= '0;
			kind_q  <= '0;
			done_q  <= 1'b0;
			prod_q  <= '0;
		end else if (go) begin
			pend_q  <= pend_n;
			phase_q <= phase_n;
			acc_q   <= acc_n;
			shift_q <= shift_n;
			first_q <= first_n;
			seg_q   <= seg_n;
			off_q   <= off_n;
			kind_q  <= kind_n;
			done_q  <= done_n;
			prod_q  <= prod_n;
		end
	end

endmodule

// ===== rtl/rebase_opcode_stream_decoder_top.sv =====
// An accepted byte is held in byte_s1; its result, if any, is registered into res_s2.
// Throughput: one stream byte per cycle unless a result waits on a full output; each byte's decode, ULEB
// digit merge and offset update finish in one pass, the stride opcode's product being
// built one 64x7 partial product per operand byte.
// Reset (arst_n low, asynchronous): stream state and pointer_bytes (to 8) clear.
module rebase_opcode_stream_decoder_top import rosd_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  stream_byte,
	input  logic        final_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic [3:0]  run_segment,
	output logic [63:0] run_offset,
	output logic [63:0] run_count,
	output logic [63:0] run_stride,
	output logic [3:0]  run_kind,
	output logic        stream_end,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic       valid_s2;
	rosd_res_t  res_s2;

	logic       go;
	logic       out_free;
	logic       res_valid;
	rosd_res_t  res;
	logic [3:0] ptr_bytes;

	rosd_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.ptr_bytes(ptr_bytes)
	);

	rosd_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.in_byte  (byte_s1),
		.in_final (final_s1),
		.ptr_bytes(ptr_bytes),
		.res_valid(res_valid),
		.res      (res)
	);

	// a byte with no result never waits on the output side
	assign out_free   = !valid_s2 || result_ready;
	assign go         = valid_s1 && (!res_valid || out_free);
	assign item_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go && res_valid) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			byte_s1  <= stream_byte;
			final_s1 <= final_byte;
		end
		if (go && res_valid) begin
			res_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign status       = res_s2.status;
	assign run_segment  = res_s2.segment;
	assign run_offset   = res_s2.offset;
	assign run_count    = res_s2.count;
	assign run_stride   = res_s2.stride;
	assign run_kind     = res_s2.kind;
	assign stream_end   = res_s2.stream_end;

endmodule

// ===== rtl/rosd_checker.sv =====
`include "assert_macros.svh"

module rosd_checker import rosd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  status,
	input logic [3:0]  run_segment,
	input logic [63:0] run_offset,
	input logic [63:0] run_count,
	input logic [63:0] run_stride,
	input logic [3:0]  run_kind,
	input logic        stream_end,
	input logic        pready
);

	logic run_fields_zero;

	assign run_fields_zero = (run_segment == 4'd0) && (run_offset == 64'd0) &&
		(run_count == 64'd0) && (run_stride == 64'd0) && (run_kind == 4'd0);

	// non-run results carry no run description
	`ASSERT_IMPL(a_status_only, clk, arst_n, result_valid && status != ST_RUN, run_fields_zero)

	// a truncated operand is only reported on the stream's last byte
	`ASSERT_IMPL(a_trunc_closes, clk, arst_n, result_valid && status == ST_TRUNC, stream_end)

	// with the output empty the input side never stalls
	`ASSERT_IMPL(a_no_stall, clk, arst_n, !result_valid, item_ready)

	// a stalled result holds its transaction
	`ASSERT_NEXT(a_out_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(status) && $stable(run_offset) && $stable(stream_end))

	`ASSERT_IMPL(a_pready, clk, arst_n, item_valid || !item_valid, pready)

endmodule

bind rebase_opcode_stream_decoder_top rosd_checker u_rosd_checker (.*);

// ===== bench/rebase_opcode_stream_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module rebase_opcode_stream_decoder_top_tb;
	import rosd_pkg::*;

	localparam logic [3:0] OP_FIRST_UNDEF = 4'h9;
	localparam logic [3:0] OP_LAST_UNDEF  = 4'hF;
	localparam logic [2:0] PTR_BYTES_ADDR = 3'(4 * REG_POINTER_BYTES);
	localparam int         SETTLE_CYCLES  = 4;
	localparam int         NUM_PHASES     = 6;
	localparam int         PHASE_BYTES    = 225;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_txn_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [7:0]  stream_byte = '0;
	logic        final_byte = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  status;
	logic [3:0]  run_segment;
	logic [63:0] run_offset;
	logic [63:0] run_count;
	logic [63:0] run_stride;
	logic [3:0]  run_kind;
	logic        stream_end;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	rebase_opcode_stream_decoder_top u_dut (.*);

	// decoder model state, mirrors the block after reset
	logic [3:0]  ptr_cfg   = PTR_BYTES_RST;
	logic [3:0]  dec_op    = OP_NONE;
	logic [1:0]  dec_phase = PH_IDLE;
	logic [63:0] leb_acc   = '0;
	logic [6:0]  leb_sh    = '0;
	logic [63:0] leb_first = '0;
	logic [3:0]  cur_seg   = '0;
	logic [63:0] cur_ofs   = '0;
	logic [3:0]  cur_kind  = '0;
	logic        dec_done  = 1'b0;

	byte_txn_t   byte_q[$];
	byte_txn_t   stream_buf[$];
	rosd_res_t   predicted_results[$];
	int          fails = 0;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          send_idle_pct = 15;
	int          recv_idle_pct = 15;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void restart_stream();
		dec_op    = OP_NONE;
		dec_phase = PH_IDLE;
		leb_acc   = '0;
		leb_sh    = '0;
		leb_first = '0;
		cur_seg   = '0;
		cur_ofs   = '0;
		cur_kind  = '0;
		dec_done  = 1'b0;
	endfunction

	function automatic logic [63:0] slot_bytes();
		return (ptr_cfg == PTR_BYTES_SMALL) ? 64'd4 : 64'd8;
	endfunction

	function automatic void emit_run(output rosd_res_t r, input logic [63:0] cnt,
			input logic [63:0] str);
		r         = '0;
		r.status  = ST_RUN;
		r.segment = cur_seg;
		r.offset  = cur_ofs;
		r.count   = cnt;
		r.stride  = str;
		r.kind    = cur_kind;
		cur_ofs   = cur_ofs + cnt * str;
	endfunction

	function automatic bit decode_byte(input byte_txn_t t, output rosd_res_t r);
		logic [3:0]  op;
		logic [3:0]  imm;
		logic [63:0] v;
		bit          hit;
		hit = 1'b0;
		r = '0;
		if (dec_done) begin
			if (t.last)
				restart_stream();
			return 1'b0;
		end
		if (dec_phase == PH_IDLE) begin
			op  = t.data[7:4];
			imm = t.data[3:0];
			case (op)
				OP_DONE: begin
					r.status = ST_FINISH;
					hit = 1'b1;
					dec_done = 1'b1;
				end
				OP_SET_KIND: cur_kind = imm;
				OP_SET_SEG: begin
					cur_seg = imm;
					dec_op = op;
					dec_phase = PH_FIRST;
				end
				OP_ADD_ULEB, OP_RUN_ULEB, OP_RUN_SKIP, OP_RUN_STRIDE: begin
					dec_op = op;
					dec_phase = PH_FIRST;
				end
				OP_ADD_IMM: cur_ofs = cur_ofs + 64'(imm) * slot_bytes();
				OP_RUN_IMM: begin
					emit_run(r, 64'(imm), slot_bytes());
					hit = 1'b1;
				end
				default: begin
					r.status = ST_UNKNOWN;
					hit = 1'b1;
					dec_done = 1'b1;
				end
			endcase
			leb_acc = '0;
			leb_sh  = '0;
			if (t.last && dec_phase != PH_IDLE) begin
				r = '0;
				r.status = ST_TRUNC;
				hit = 1'b1;
			end
		end else begin
			// digits past bit 63 are dropped, the shift saturates at 70
			if (leb_sh < 64)
				leb_acc = leb_acc | (64'(t.data[6:0]) << leb_sh);
			if (t.data[7]) begin
				if (leb_sh < 70)
					leb_sh = leb_sh + 7'd7;
				if (t.last) begin
					r.status = ST_TRUNC;
					hit = 1'b1;
				end
			end else begin
				v = leb_acc;
				leb_acc = '0;
				leb_sh  = '0;
				if (dec_op == OP_RUN_STRIDE && dec_phase == PH_FIRST) begin
					leb_first = v;
					dec_phase = PH_SECOND;
					if (t.last) begin
						r.status = ST_TRUNC;
						hit = 1'b1;
					end
				end else begin
					case (dec_op)
						OP_SET_SEG:  cur_ofs = v;
						OP_ADD_ULEB: cur_ofs = cur_ofs + v;
						OP_RUN_ULEB: begin
							emit_run(r, v, slot_bytes());
							hit = 1'b1;
						end
						OP_RUN_SKIP: begin
							emit_run(r, 64'd1, slot_bytes() + v);
							hit = 1'b1;
						end
						OP_RUN_STRIDE: begin
							emit_run(r, leb_first, v + slot_bytes());
							hit = 1'b1;
						end
						default: ;
					endcase
					dec_op = OP_NONE;
					dec_phase = PH_IDLE;
				end
			end
		end
		if (t.last) begin
			if (!hit) begin
				r.status = ST_FINISH;
				hit = 1'b1;
			end
			r.stream_end = 1'b1;
			restart_stream();
		end
		return hit;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fails++;
		end
	endfunction

	// byte sender; the model advances on each accepted transaction
	always @(posedge clk) begin
		rosd_res_t run_info;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				if (decode_byte({stream_byte, final_byte}, run_info))
					predicted_results.insert(predicted_results.size(), run_info);
				void'(byte_q.pop_front());
			end
			if (!item_valid || item_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (byte_q.size() == 0) begin
					item_valid <= 1'b0;
				end else if ($urandom_range(99) < send_idle_pct) begin
					send_gap = $urandom_range(0, 17);
					item_valid <= 1'b0;
				end else begin
					item_valid  <= 1'b1;
					stream_byte <= byte_q[0].data;
					final_byte  <= byte_q[0].last;
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		rosd_res_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (predicted_results.size() == 0) begin
					$error("unexpected result, status %0d", status);
					fails++;
				end else begin
					want = predicted_results.pop_front();
					check_field("status", 64'(want.status), 64'(status));
					check_field("run_segment", 64'(want.segment), 64'(run_segment));
					check_field("run_offset", want.offset, run_offset);
					check_field("run_count", want.count, run_count);
					check_field("run_stride", want.stride, run_stride);
					check_field("run_kind", 64'(want.kind), 64'(run_kind));
					check_field("stream_end", 64'(want.stream_end), 64'(stream_end));
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				result_ready <= 1'b0;
			end else if ($urandom_range(99) < recv_idle_pct) begin
				recv_gap = $urandom_range(0, 17);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PTR_BYTES_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_pointer_bytes(input logic [3:0] val, input bit junk_upper);
		logic [31:0] rd;
		apb_access(1'b1, {(junk_upper ? 28'($urandom) : 28'd0), val}, rd);
		ptr_cfg = val;
		apb_access(1'b0, '0, rd);
		check_field("prdata", 64'({28'd0, ptr_cfg}), 64'(rd));
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (byte_q.size() != 0 || item_valid || predicted_results.size() != 0);
		// bytes without a result may still be in the pipe
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_uleb();
		int len;
		int sel;
		sel = $urandom_range(99);
		if (sel < 45)
			len = 1;
		else if (sel < 75)
			len = $urandom_range(2, 4);
		else if (sel < 93)
			len = $urandom_range(5, 10);
		else
			len = $urandom_range(11, 13);
		for (int i = 0; i < len; i++)
			stream_buf.insert(stream_buf.size(), {1'(i < len - 1), 7'($urandom), 1'b0});
	endfunction

	function automatic void push_op();
		logic [3:0] op;
		int         sel;
		sel = $urandom_range(99);
		if (sel < 8)
			op = OP_SET_KIND;
		else if (sel < 18)
			op = OP_SET_SEG;
		else if (sel < 28)
			op = OP_ADD_ULEB;
		else if (sel < 38)
			op = OP_ADD_IMM;
		else if (sel < 55)
			op = OP_RUN_IMM;
		else if (sel < 70)
			op = OP_RUN_ULEB;
		else if (sel < 85)
			op = OP_RUN_SKIP;
		else
			op = OP_RUN_STRIDE;
		stream_buf.insert(stream_buf.size(), {op, 4'($urandom), 1'b0});
		case (op)
			OP_SET_SEG, OP_ADD_ULEB, OP_RUN_ULEB, OP_RUN_SKIP: push_uleb();
			OP_RUN_STRIDE: begin
				push_uleb();
				push_uleb();
			end
			default: ;
		endcase
	endfunction

	task automatic add_random_streams(input int n_bytes);
		int sent;
		int kind;
		int cut;
		sent = 0;
		while (sent < n_bytes) begin
			stream_buf.delete();
			kind = $urandom_range(99);
			if (kind < 8) begin
				// line noise, with an occasional end marker
				repeat ($urandom_range(1, 6))
					stream_buf.insert(stream_buf.size(),
						{8'($urandom), 1'($urandom_range(7) == 0)});
			end else begin
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(39) == 0)
						stream_buf.insert(stream_buf.size(),
							{4'($urandom_range(OP_FIRST_UNDEF, OP_LAST_UNDEF)),
							4'($urandom), 1'b0});
					else
						push_op();
				end
				if (kind < 80) begin
					if ($urandom_range(2) == 0) begin
						stream_buf.insert(stream_buf.size(),
							{OP_DONE, 4'($urandom), 1'b0});
						repeat ($urandom_range(0, 3))
							stream_buf.insert(stream_buf.size(), {8'($urandom), 1'b0});
					end
				end else begin
					// stream cut short at an arbitrary byte
					cut = $urandom_range(0, stream_buf.size() - 1);
					while (stream_buf.size() > cut + 1)
						void'(stream_buf.pop_back());
				end
				stream_buf[stream_buf.size() - 1].last = 1'b1;
			end
			sent += stream_buf.size();
			foreach (stream_buf[i])
				byte_q.insert(byte_q.size(), stream_buf[i]);
		end
	endtask

	task automatic add_directed();
		// run straight from the reset state
		byte_q.insert(byte_q.size(), {OP_RUN_IMM, 4'd2, 1'b0});
		byte_q.insert(byte_q.size(), {OP_SET_KIND, 4'hF, 1'b0});
		byte_q.insert(byte_q.size(), {OP_SET_SEG, 4'hF, 1'b0});
		byte_q.insert(byte_q.size(), {8'h80, 1'b0});
		byte_q.insert(byte_q.size(), {8'h01, 1'b0});
		byte_q.insert(byte_q.size(), {OP_ADD_IMM, 4'hF, 1'b0});
		// zero counts leave the offset; then a skip run and a stride run with a two-digit operand
		byte_q.insert(byte_q.size(), {OP_RUN_IMM, 4'd0, 1'b0});
		byte_q.insert(byte_q.size(), {OP_RUN_ULEB, 4'd0, 1'b0});
		byte_q.insert(byte_q.size(), {8'h00, 1'b0});
		byte_q.insert(byte_q.size(), {OP_RUN_SKIP, 4'd0, 1'b0});
		byte_q.insert(byte_q.size(), {8'h7F, 1'b0});
		byte_q.insert(byte_q.size(), {OP_RUN_STRIDE, 4'd0, 1'b0});
		byte_q.insert(byte_q.size(), {8'h02, 1'b0});
		byte_q.insert(byte_q.size(), {8'h83, 1'b0});
		byte_q.insert(byte_q.size(), {8'h01, 1'b0});
		// done, then junk ignored until the end marker
		byte_q.insert(byte_q.size(), {OP_DONE, 4'd0, 1'b0});
		byte_q.insert(byte_q.size(), {8'hFF, 1'b0});
		byte_q.insert(byte_q.size(), {OP_RUN_IMM, 4'd1, 1'b1});
		// truncations: opcode, continued digit, first of two operands
		byte_q.insert(byte_q.size(), {OP_RUN_ULEB, 4'd3, 1'b1});
		byte_q.insert(byte_q.size(), {OP_ADD_ULEB, 4'd0, 1'b0});
		byte_q.insert(byte_q.size(), {8'h80, 1'b1});
		byte_q.insert(byte_q.size(), {OP_RUN_STRIDE, 4'd0, 1'b0});
		byte_q.insert(byte_q.size(), {8'h04, 1'b1});
		// unknown opcodes, plain end, run on the last byte
		byte_q.insert(byte_q.size(), {OP_LAST_UNDEF, 4'hF, 1'b1});
		byte_q.insert(byte_q.size(), {OP_FIRST_UNDEF, 4'd0, 1'b0});
		byte_q.insert(byte_q.size(), {8'h00, 1'b1});
		byte_q.insert(byte_q.size(), {OP_SET_KIND, 4'd1, 1'b1});
		byte_q.insert(byte_q.size(), {OP_RUN_IMM, 4'd3, 1'b1});
	endtask

	initial begin
		logic [31:0] rd;
		logic [3:0]  ptr_plan [NUM_PHASES];
		int          idle_plan [NUM_PHASES];
		ptr_plan  = '{PTR_BYTES_SMALL, 4'd15, 4'd0, PTR_BYTES_RST, 4'd5, PTR_BYTES_SMALL};
		idle_plan = '{20, 35, 0, 10, 25, 0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		apb_access(1'b0, '0, rd);
		check_field("prdata", 64'({28'd0, PTR_BYTES_RST}), 64'(rd));
		add_directed();
		wait_idle();
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_pointer_bytes((ph == 4) ? 4'($urandom) : ptr_plan[ph], ph[0]);
			send_idle_pct = idle_plan[ph];
			recv_idle_pct = idle_plan[ph];
			add_random_streams(PHASE_BYTES);
			wait_idle();
		end
		repeat (10) @(posedge clk);
		if (fails == 0 && predicted_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== rebase_opcode_stream_decoder_top.f =====
+incdir+rtl
rtl/rosd_pkg.sv
rtl/rosd_regs.sv
rtl/rosd_core.sv
rtl/rebase_opcode_stream_decoder_top.sv
rtl/rosd_checker.sv
bench/rebase_opcode_stream_decoder_top_tb.sv
